FILE: rtl/dpod_pkg.sv
// Shared types and codes for the delta patch operation decoder.
package dpod_pkg;

    // Parse phase of the operation stream.
    typedef enum logic [1:0] {
        PH_OPCODE  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_DELTA   = 2'd2,
        PH_UNKNOWN = 2'd3
    } phase_t;

    // Command kinds.
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_COPY   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // Error codes.
    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_OVERLONG  = 4'd1,
        ERR_EMPTY_RUN = 4'd2,
        ERR_TARGET    = 4'd3,
        ERR_LITERAL   = 4'd4,
        ERR_COPY      = 4'd5,
        ERR_BAD_OP    = 4'd6,
        ERR_CUT_SHORT = 4'd7,
        ERR_EXCESS    = 4'd8
    } err_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SOURCE_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_TARGET_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_LITERAL_LENGTH = 3'd2;
    localparam logic [2:0] CFG_ADD_OPCODE     = 3'd3;
    localparam logic [2:0] CFG_COPY_OPCODE    = 3'd4;

    // LEB128 field masks and limits.
    localparam logic [6:0] VARINT_DATA_MASK = 7'h7F;
    localparam logic [6:0] VARINT_LAST_MAX  = 7'h0F;
    localparam logic [2:0] VARINT_MAX_COUNT = 3'd4;

    typedef struct packed {
        logic [31:0] source_length;
        logic [31:0] target_length;
        logic [31:0] literal_length;
        logic [7:0]  add_opcode;
        logic [7:0]  copy_opcode;
    } cfg_t;

    typedef struct packed {
        phase_t      parse_phase;
        logic [31:0] varint_value;
        logic [2:0]  varint_byte_count;
        logic        pending_is_copy;
        logic [31:0] pending_length;
        logic [31:0] previous_copy_end;
        logic [31:0] target_position;
        logic [31:0] literal_position;
        logic        halted;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic        stream_done;
        logic [31:0] run_length;
        logic [31:0] source_offset;
        logic [31:0] literal_offset;
        logic [31:0] target_offset;
    } result_t;

endpackage

FILE: rtl/dpod_stream_if.sv
// Valid/ready channel interfaces for operation bytes and decoded commands.
interface dpod_ops_if;
    logic       valid;
    logic       ready;
    logic [7:0] ops_byte;
    logic       last_byte;

    modport source (output valid, output ops_byte, output last_byte, input ready);
    modport sink (input valid, input ops_byte, input last_byte, output ready);
endinterface

interface dpod_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic        stream_done;
    logic [31:0] run_length;
    logic [31:0] source_offset;
    logic [31:0] literal_offset;
    logic [31:0] target_offset;

    modport source (output valid, output kind, output error_code, output stream_done,
                    output run_length, output source_offset, output literal_offset,
                    output target_offset, input ready);
    modport sink (input valid, input kind, input error_code, input stream_done,
                  input run_length, input source_offset, input literal_offset,
                  input target_offset, output ready);
endinterface

FILE: rtl/dpod_step.sv
// Combinational next-state and command logic for one operation stream byte.
module dpod_step (
    input  dpod_pkg::cfg_t    cfg,
    input  dpod_pkg::state_t  state,
    input  logic [7:0]        ops_byte,
    input  logic              last_byte,
    output dpod_pkg::state_t  state_next,
    output logic              res_valid,
    output dpod_pkg::result_t res
);
    import dpod_pkg::*;

    logic [6:0]  data7;
    logic [4:0]  shift_amt;
    logic [31:0] v_full;
    logic        cnt_max;
    logic [31:0] tgt_room;
    logic [31:0] lit_room;
    logic [31:0] mag;
    logic [33:0] ofs;
    logic        ofs_bad;
    logic [31:0] so_val;
    logic        copy_len_bad;
    logic [31:0] cmd_len;
    logic [31:0] tpos_new;
    logic [31:0] lpos_new;
    err_t        err;
    logic        finish;
    logic        done;
    kind_t       cmd_kind;
    logic [31:0] cmd_so;
    logic [31:0] cmd_lo;

    // Bit position of the current LEB128 group.
    always_comb
    begin
        case (state.varint_byte_count)
            3'd0:    shift_amt = 5'd0;
            3'd1:    shift_amt = 5'd7;
            3'd2:    shift_amt = 5'd14;
            3'd3:    shift_amt = 5'd21;
            default: shift_amt = 5'd28;
        endcase
    end

    // Varint accumulation and the room left in the target and literal streams.
    assign data7    = ops_byte[6:0] & VARINT_DATA_MASK;
    assign v_full   = state.varint_value | (32'(data7) << shift_amt);
    assign cnt_max  = state.varint_byte_count >= VARINT_MAX_COUNT;
    assign tgt_room = (state.target_position < cfg.target_length)
                    ? cfg.target_length - state.target_position : 32'd0;
    assign lit_room = (state.literal_position < cfg.literal_length)
                    ? cfg.literal_length - state.literal_position : 32'd0;

    // Zigzag delta applied to the previous copy end, kept wide enough for the sign.
    assign mag = {1'b0, v_full[31:1]};
    assign ofs = v_full[0] ? ({2'b00, state.previous_copy_end} - {2'b00, mag} - 34'd1)
                           : ({2'b00, state.previous_copy_end} + {2'b00, mag});
    assign ofs_bad      = ofs[33] || (ofs[32:0] > {1'b0, cfg.source_length});
    assign so_val       = ofs[31:0];
    assign copy_len_bad = state.pending_length > (cfg.source_length - so_val);

    // Positions after a finished command.
    assign cmd_len  = (state.parse_phase == PH_DELTA) ? state.pending_length : v_full;
    assign tpos_new = state.target_position + cmd_len;
    assign lpos_new = state.literal_position + v_full;

    // Parse one byte.
    always_comb
    begin
        state_next = state;
        err        = ERR_OK;
        finish     = 1'b0;
        done       = 1'b0;
        cmd_kind   = KIND_ADD;
        cmd_so     = 32'd0;
        cmd_lo     = 32'd0;
        if (!state.halted)
        begin
            case (state.parse_phase)
                PH_OPCODE:
                begin
                    if (ops_byte == cfg.add_opcode)
                    begin
                        state_next.pending_is_copy = 1'b0;
                        state_next.parse_phase     = PH_LENGTH;
                    end
                    else if (ops_byte == cfg.copy_opcode)
                    begin
                        state_next.pending_is_copy = 1'b1;
                        state_next.parse_phase     = PH_LENGTH;
                    end
                    else
                    begin
                        state_next.pending_is_copy = 1'b0;
                        state_next.parse_phase     = PH_UNKNOWN;
                    end
                    state_next.varint_value      = 32'd0;
                    state_next.varint_byte_count = 3'd0;
                    if (last_byte)
                    begin
                        err = ERR_CUT_SHORT;
                    end
                end
                default:
                begin
                    if (cnt_max && (data7 > VARINT_LAST_MAX))
                    begin
                        err = ERR_OVERLONG;
                    end
                    else if (ops_byte[7])
                    begin
                        if (cnt_max)
                        begin
                            err = ERR_OVERLONG;
                        end
                        else
                        begin
                            state_next.varint_value      = v_full;
                            state_next.varint_byte_count = state.varint_byte_count + 3'd1;
                            if (last_byte)
                            begin
                                err = ERR_CUT_SHORT;
                            end
                        end
                    end
                    else
                    begin
                        state_next.varint_value      = 32'd0;
                        state_next.varint_byte_count = 3'd0;
                        if (state.parse_phase != PH_DELTA)
                        begin
                            // Length field of an add, a copy or an unknown opcode.
                            if (v_full == 32'd0)
                            begin
                                err = ERR_EMPTY_RUN;
                            end
                            else if (v_full > tgt_room)
                            begin
                                err = ERR_TARGET;
                            end
                            else if (state.parse_phase == PH_UNKNOWN)
                            begin
                                err = ERR_BAD_OP;
                            end
                            else if (state.pending_is_copy)
                            begin
                                state_next.pending_length = v_full;
                                state_next.parse_phase    = PH_DELTA;
                                if (last_byte)
                                begin
                                    err = ERR_CUT_SHORT;
                                end
                            end
                            else if (v_full > lit_room)
                            begin
                                err = ERR_LITERAL;
                            end
                            else
                            begin
                                finish                      = 1'b1;
                                cmd_kind                    = KIND_ADD;
                                cmd_lo                      = state.literal_position;
                                state_next.pending_length   = v_full;
                                state_next.literal_position = lpos_new;
                            end
                        end
                        else
                        begin
                            // Source delta of a copy.
                            if (ofs_bad || copy_len_bad)
                            begin
                                err = ERR_COPY;
                            end
                            else
                            begin
                                finish                       = 1'b1;
                                cmd_kind                     = KIND_COPY;
                                cmd_so                       = so_val;
                                state_next.previous_copy_end = so_val + state.pending_length;
                            end
                        end

                        // A finished command advances the target and checks the stream end.
                        if (finish)
                        begin
                            state_next.parse_phase     = PH_OPCODE;
                            state_next.target_position = tpos_new;
                            if (tpos_new >= cfg.target_length)
                            begin
                                if (!last_byte
                                    || (state_next.literal_position != cfg.literal_length))
                                begin
                                    err = ERR_EXCESS;
                                end
                                else
                                begin
                                    done              = 1'b1;
                                    state_next.halted = 1'b1;
                                end
                            end
                            else if (last_byte)
                            begin
                                err = ERR_CUT_SHORT;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // An error replaces any command; the top level halts the decoder on it.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (err != ERR_OK)
        begin
            res_valid      = 1'b1;
            res.kind       = KIND_STATUS;
            res.error_code = err;
        end
        else if (finish)
        begin
            res_valid          = 1'b1;
            res.kind           = cmd_kind;
            res.error_code     = ERR_OK;
            res.stream_done    = done;
            res.run_length     = cmd_len;
            res.source_offset  = cmd_so;
            res.literal_offset = cmd_lo;
            res.target_offset  = state.target_position;
        end
    end

endmodule

FILE: rtl/delta_patch_op_decoder.sv
// Top level of the delta patch operation decoder: registers, handshakes and checks.
//
// The decoder takes one operation stream byte per clock while the command side keeps
// up. An accepted byte lands in an input register, and its parse is written to the
// parser state at the edge on which it leaves that register; any command or status it
// causes is loaded into a result register at that edge and offered from there until it
// is taken. The parser state loop (varint accumulation, position adds and range
// compares) is combinational between parser state register updates, which allows the
// one-byte-per-clock rate. A byte leaves the input register only when the result
// register is empty or being emptied, whether or not the byte makes a result, so
// while a result waits untaken the input register takes one more byte and then the
// input stalls. After an error or completion the decoder discards further bytes
// until reset.
module delta_patch_op_decoder (
    input  logic            clk,
    input  logic            rst_n,
    dpod_ops_if.sink        ops,
    dpod_cmd_if.source      cmd,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import dpod_pkg::*;

    cfg_t        cfg_reg;
    state_t      state_reg;
    state_t      step_state;
    state_t      state_next;
    logic        ops_valid_reg;
    logic [7:0]  ops_byte_reg;
    logic        last_byte_reg;
    logic        cmd_valid_reg;
    result_t     cmd_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    // The parsed byte moves on when the result register can take its result.
    assign advance   = ops_valid_reg && (!cmd_valid_reg || cmd.ready);
    assign ops.ready = !ops_valid_reg || advance;

    dpod_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .ops_byte   (ops_byte_reg),
        .last_byte  (last_byte_reg),
        .state_next (step_state),
        .res_valid  (res_valid),
        .res        (res)
    );

    // An error result halts the parser as well.
    always_comb
    begin
        state_next = step_state;
        if (res_valid && (res.error_code != ERR_OK))
        begin
            state_next.halted = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_length  <= 32'd1;
            cfg_reg.target_length  <= 32'd1;
            cfg_reg.literal_length <= 32'd0;
            cfg_reg.add_opcode     <= 8'd0;
            cfg_reg.copy_opcode    <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_LENGTH:  cfg_reg.source_length  <= cfg_data;
                CFG_TARGET_LENGTH:  cfg_reg.target_length  <= cfg_data;
                CFG_LITERAL_LENGTH: cfg_reg.literal_length <= cfg_data;
                CFG_ADD_OPCODE:     cfg_reg.add_opcode     <= cfg_data[7:0];
                CFG_COPY_OPCODE:    cfg_reg.copy_opcode    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_valid_reg <= 1'b0;
        end
        else if (ops.ready)
        begin
            ops_valid_reg <= ops.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.valid && ops.ready)
        begin
            ops_byte_reg  <= ops.ops_byte;
            last_byte_reg <= ops.last_byte;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{parse_phase: PH_OPCODE, default: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            cmd_reg <= res;
        end
    end

    assign cmd.valid          = cmd_valid_reg;
    assign cmd.kind           = cmd_reg.kind;
    assign cmd.error_code     = cmd_reg.error_code;
    assign cmd.stream_done    = cmd_reg.stream_done;
    assign cmd.run_length     = cmd_reg.run_length;
    assign cmd.source_offset  = cmd_reg.source_offset;
    assign cmd.literal_offset = cmd_reg.literal_offset;
    assign cmd.target_offset  = cmd_reg.target_offset;

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |=> state_reg.halted)
        else $error("parser left the halted state");

    // A halted parser never loads a new result.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.halted && !cmd_valid_reg) |=> !cmd_valid_reg)
        else $error("result produced after halt");

    // Completion comes only on a clean command and halts the parser.
    a_done_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.stream_done) |=>
            (state_reg.halted && cmd_reg.error_code == ERR_OK
             && cmd_reg.kind != KIND_STATUS))
        else $error("completion without a clean command or halt");

    // A status result always carries an error and no run.
    a_status_error: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && cmd_reg.kind == KIND_STATUS) |->
            (cmd_reg.error_code != ERR_OK && cmd_reg.run_length == 32'd0))
        else $error("status result without error code");

    // An error result halts the parser in the same step.
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.error_code != ERR_OK) |=> state_reg.halted)
        else $error("error did not halt the parser");
endmodule

FILE: tb/delta_patch_op_decoder_tb.sv
// Self-checking testbench for the delta patch operation decoder with a built-in command predictor.
module delta_patch_op_decoder_tb;
    import dpod_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } op_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    dpod_ops_if ops_ch ();
    dpod_cmd_if cmd_ch ();

    delta_patch_op_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .ops       (ops_ch),
        .cmd       (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pending stream bytes and the commands the decoder owes us.
    op_byte_t byte_q[$];
    result_t  expected_cmds[$];
    cfg_t     regs;
    int       bytes_queued;
    int       bytes_taken = 0;
    int       fault_count = 0;

    // Handshake bookkeeping: the monitor counts accepted items, each side tracks its own.
    int bytes_sent = 0;
    int cmds_taken = 0;
    int cmds_seen = 0;
    bit ops_bursty = 1'b1;
    bit cmd_bursty = 1'b1;
    int ops_wait = 0;
    int cmd_wait = 0;

    // Mirror of the parser state.
    phase_t      m_phase = PH_OPCODE;
    logic [31:0] m_acc = '0;
    int          m_count = 0;
    logic        m_is_copy = 1'b0;
    logic [31:0] m_len = '0;
    logic [31:0] m_prev_end = '0;
    logic [31:0] m_tpos = '0;
    logic [31:0] m_lpos = '0;
    bit          m_halted = 1'b0;

    // Positions the stimulus has already committed to.
    logic [31:0] g_tpos;
    logic [31:0] g_lpos;
    logic [31:0] g_prev_end;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] room_left(input logic [31:0] limit, input logic [31:0] pos);
        return (pos < limit) ? limit - pos : 32'd0;
    endfunction

    // An error stops the parser for good and yields a status-only command.
    function automatic void report_error(input err_t code);
        result_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.error_code = code;
        m_halted = 1'b1;
        expected_cmds.push_back(r);
    endfunction

    // Advance the parser mirror by one stream byte and queue any command it finishes.
    function automatic void decode_op_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [31:0] v;
        logic [31:0] so;
        longint      mag;
        longint      ofs;
        longint      src;
        r = '0;
        if (m_halted)
            return;

        if (m_phase == PH_OPCODE)
        begin
            if (b == regs.add_opcode)
            begin
                m_is_copy = 1'b0;
                m_phase = PH_LENGTH;
            end
            else if (b == regs.copy_opcode)
            begin
                m_is_copy = 1'b1;
                m_phase = PH_LENGTH;
            end
            else
            begin
                m_is_copy = 1'b0;
                m_phase = PH_UNKNOWN;
            end
            m_acc = '0;
            m_count = 0;
            if (last)
                report_error(ERR_CUT_SHORT);
            return;
        end

        // Varint byte: the fifth one may carry only four data bits and no continuation.
        if (m_count >= VARINT_MAX_COUNT && b[6:0] > VARINT_LAST_MAX)
        begin
            report_error(ERR_OVERLONG);
            return;
        end
        m_acc = m_acc | ({25'd0, b[6:0]} << (7 * m_count));
        if (b[7])
        begin
            if (m_count >= VARINT_MAX_COUNT)
            begin
                report_error(ERR_OVERLONG);
                return;
            end
            m_count++;
            if (last)
                report_error(ERR_CUT_SHORT);
            return;
        end
        v = m_acc;
        m_acc = '0;
        m_count = 0;

        if (m_phase == PH_LENGTH || m_phase == PH_UNKNOWN)
        begin
            if (v == 0)
            begin
                report_error(ERR_EMPTY_RUN);
                return;
            end
            if (v > room_left(regs.target_length, m_tpos))
            begin
                report_error(ERR_TARGET);
                return;
            end
            if (m_phase == PH_UNKNOWN)
            begin
                report_error(ERR_BAD_OP);
                return;
            end
            if (m_is_copy)
            begin
                m_len = v;
                m_phase = PH_DELTA;
                if (last)
                    report_error(ERR_CUT_SHORT);
                return;
            end
            if (v > room_left(regs.literal_length, m_lpos))
            begin
                report_error(ERR_LITERAL);
                return;
            end
            r.kind = KIND_ADD;
            r.literal_offset = m_lpos;
            m_len = v;
            m_lpos = m_lpos + v;
        end
        else
        begin
            // Zigzag source delta, taken from the end of the previous copy.
            mag = v >> 1;
            ofs = m_prev_end;
            ofs = v[0] ? ofs - mag - 1 : ofs + mag;
            src = regs.source_length;
            if (ofs < 0 || ofs > src)
            begin
                report_error(ERR_COPY);
                return;
            end
            so = 32'(ofs);
            if (m_len > regs.source_length - so)
            begin
                report_error(ERR_COPY);
                return;
            end
            m_prev_end = so + m_len;
            r.kind = KIND_COPY;
            r.source_offset = so;
        end

        m_phase = PH_OPCODE;
        r.run_length = m_len;
        r.target_offset = m_tpos;
        m_tpos = m_tpos + m_len;

        // Filling the target ends the stream; it must coincide with the last byte.
        if (m_tpos >= regs.target_length)
        begin
            if (!last || m_lpos != regs.literal_length)
            begin
                report_error(ERR_EXCESS);
                return;
            end
            m_halted = 1'b1;
            r.stream_done = 1'b1;
            expected_cmds.push_back(r);
            return;
        end
        if (last)
        begin
            report_error(ERR_CUT_SHORT);
            return;
        end
        expected_cmds.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic last);
        byte_q.push_back(op_byte_t'{b, last});
        bytes_queued++;
    endfunction

    // LEB128 encoding, optionally padded with redundant continuation bytes.
    function automatic void put_varint(input logic [31:0] value, input int width,
                                       input logic last);
        int n;
        int i;
        n = 1;
        while (n < 5 && (value >> (7 * n)) != 0)
            n++;
        if (width > n)
            n = width;
        for (i = 0; i < n; i++)
            put_byte({i < n - 1, 7'(value >> (7 * i))}, last && i == n - 1);
    endfunction

    function automatic int pad_width();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1;
    endfunction

    function automatic logic [31:0] zigzag(input longint d);
        return (d >= 0) ? 32'(2 * d) : 32'(-2 * d - 1);
    endfunction

    function automatic void put_add(input logic [31:0] len, input int pad, input logic last);
        put_byte(regs.add_opcode, 1'b0);
        put_varint(len, pad, last);
        g_tpos = g_tpos + len;
        g_lpos = g_lpos + len;
    endfunction

    function automatic void put_copy(input logic [31:0] len, input logic [31:0] so,
                                     input int pad, input logic last);
        longint d;
        longint pe;
        d = so;
        pe = g_prev_end;
        d = d - pe;
        put_byte(regs.copy_opcode, 1'b0);
        put_varint(len, pad, 1'b0);
        put_varint(zigzag(d), pad, last);
        g_tpos = g_tpos + len;
        g_prev_end = so + len;
    endfunction

    // A well-formed operation with random length, padding and source offset.
    function automatic void put_random_op();
        logic [31:0] len;
        logic [31:0] so;
        logic [31:0] step;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            len = $urandom_range(1, 127);
        else if (sel < 9)
            len = $urandom_range(128, 16383);
        else
            len = $urandom_range(16384, 1 << 20);
        if (regs.add_opcode == regs.copy_opcode || $urandom_range(0, 1) == 0)
        begin
            put_add(len, pad_width(), 1'b0);
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                step = $urandom_range(0, 4096);
                so = (g_prev_end < step) ? 32'd0 : g_prev_end - step;
            end
            else
            begin
                so = g_prev_end + $urandom_range(0, 65535);
            end
            if (so > regs.source_length - len)
                so = regs.source_length - len;
            put_copy(len, so, pad_width(), 1'b0);
        end
    endfunction

    task automatic wait_idle();
        while (bytes_taken != bytes_queued || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write every register in turn; only called while the decoder is idle.
    task automatic set_all(input logic [31:0] src, input logic [31:0] tgt,
                           input logic [31:0] lit, input logic [7:0] add_op,
                           input logic [7:0] copy_op);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SOURCE_LENGTH;
        cfg_data <= src;
        @(negedge clk);
        cfg_index <= CFG_TARGET_LENGTH;
        cfg_data <= tgt;
        @(negedge clk);
        cfg_index <= CFG_LITERAL_LENGTH;
        cfg_data <= lit;
        @(negedge clk);
        cfg_index <= CFG_ADD_OPCODE;
        cfg_data <= {24'd0, add_op};
        @(negedge clk);
        cfg_index <= CFG_COPY_OPCODE;
        cfg_data <= {24'd0, copy_op};
        @(negedge clk);
        cfg_we <= 1'b0;
        regs = '{src, tgt, lit, add_op, copy_op};
    endtask

    task automatic run_random_phase(input int n_bytes);
        int stop_at;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at)
            put_random_op();
        wait_idle();
    endtask

    // Byte driver: holds each item until taken, then waits a random gap.
    always @(negedge clk)
    begin
        op_byte_t item;
        if (!rst_n)
        begin
            ops_ch.valid <= 1'b0;
            ops_ch.ops_byte <= '0;
            ops_ch.last_byte <= 1'b0;
        end
        else if (bytes_sent == bytes_taken)
        begin
            if (ops_wait > 0)
            begin
                ops_wait--;
                ops_ch.valid <= 1'b0;
            end
            else if (byte_q.size() != 0)
            begin
                item = byte_q.pop_front();
                ops_ch.valid <= 1'b1;
                ops_ch.ops_byte <= item.data;
                ops_ch.last_byte <= item.last;
                bytes_sent++;
                if ($urandom_range(0, 49) == 0)
                    ops_bursty = !ops_bursty;
                ops_wait = ops_bursty ? $urandom_range(0, 10) : 0;
            end
            else
            begin
                ops_ch.valid <= 1'b0;
            end
        end
    end

    // Command sink: stalls for a random gap after each item it takes.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
        end
        else
        begin
            if (cmds_seen != cmds_taken)
            begin
                cmds_seen = cmds_taken;
                if ($urandom_range(0, 49) == 0)
                    cmd_bursty = !cmd_bursty;
                cmd_wait = cmd_bursty ? $urandom_range(0, 10) : 0;
            end
            if (cmd_wait > 0)
            begin
                cmd_wait--;
                cmd_ch.ready <= 1'b0;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: check finished commands first, then feed accepted bytes to the predictor.
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmds_taken++;
                seen.kind = kind_t'(cmd_ch.kind);
                seen.error_code = err_t'(cmd_ch.error_code);
                seen.stream_done = cmd_ch.stream_done;
                seen.run_length = cmd_ch.run_length;
                seen.source_offset = cmd_ch.source_offset;
                seen.literal_offset = cmd_ch.literal_offset;
                seen.target_offset = cmd_ch.target_offset;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected command, expected none, actual %h", $time, seen);
                    fault_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("kind", 32'(want.kind), 32'(seen.kind));
                    check_field("error_code", 32'(want.error_code), 32'(seen.error_code));
                    check_field("stream_done", 32'(want.stream_done), 32'(seen.stream_done));
                    check_field("run_length", want.run_length, seen.run_length);
                    check_field("source_offset", want.source_offset, seen.source_offset);
                    check_field("literal_offset", want.literal_offset, seen.literal_offset);
                    check_field("target_offset", want.target_offset, seen.target_offset);
                end
            end
            if (ops_ch.valid && ops_ch.ready)
            begin
                bytes_taken++;
                decode_op_byte(ops_ch.ops_byte, ops_ch.last_byte);
            end
        end
    end

    // Stimulus: directed extremes, random phases under changing registers, one ending.
    initial
    begin
        int          term;
        int          p;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [7:0]  u;
        logic [31:0] len;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] lit;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        regs = '{32'd1, 32'd1, 32'd0, 8'd0, 8'd1};
        g_tpos = '0;
        g_lpos = '0;
        g_prev_end = '0;
        bytes_queued = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: widest limits, extreme opcodes, 5-byte varints, extreme deltas.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF);
        put_add(32'd1, 1, 1'b0);
        put_copy(32'h8000_0000, 32'h10, 1, 1'b0);
        put_copy(32'd1, 32'h10, 1, 1'b0);
        put_copy(32'd3, g_prev_end + 32'h7FFF_FFFF, 1, 1'b0);
        put_add(32'd5, 5, 1'b0);
        wait_idle();

        // Swapped extreme opcodes.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        run_random_phase(110);

        // Both opcodes equal: every operation decodes as an add.
        a = 8'($urandom_range(0, 255));
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, a, a);
        run_random_phase(80);

        // Random opcodes and tighter, but still roomy, limits.
        for (p = 0; p < 3; p++)
        begin
            a = 8'($urandom_range(0, 255));
            do
                c = 8'($urandom_range(0, 255));
            while (c == a);
            src = 32'hC000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
            tgt = g_tpos + 32'h1000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
            lit = g_lpos + 32'h1000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
            set_all(src, tgt, lit, a, c);
            run_random_phase(110);
        end

        // Ending: completion or one terminal error, then bytes the halted decoder drops.
        term = $urandom_range(0, 12);
        a = 8'($urandom_range(0, 255));
        do
            c = 8'($urandom_range(0, 255));
        while (c == a);
        src = regs.source_length;
        tgt = regs.target_length;
        lit = regs.literal_length;
        len = $urandom_range(1, 300);
        case (term)
            0:
            begin
                tgt = g_tpos + len;
                lit = g_lpos + len;
            end
            1:
            begin
                tgt = g_tpos + len;
                lit = g_lpos;
            end
            2: tgt = g_tpos + len;
            3:
            begin
                tgt = g_tpos + len;
                lit = g_lpos + len + 1;
            end
            9: tgt = 32'd1;
            10: lit = 32'd0;
            11: src = $urandom_range(0, 1) ? 32'd1 : g_prev_end;
            default: ;
        endcase
        set_all(src, tgt, lit, a, c);
        case (term)
            0: put_add(len, pad_width(), 1'b1);
            1: put_copy(len, g_prev_end, pad_width(), 1'b1);
            2: put_add(len, pad_width(), 1'b0);
            3: put_add(len, pad_width(), 1'b1);
            4:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    put_byte(a, 1'b1);
                end
                else
                begin
                    put_byte(c, 1'b0);
                    put_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
                end
            end
            5: put_add(len, pad_width(), 1'b1);
            6:
            begin
                put_byte(a, 1'b0);
                repeat (4) put_byte(8'h80, 1'b0);
                put_byte(8'($urandom_range(16, 127)) | 8'($urandom_range(0, 1) << 7),
                         1'($urandom_range(0, 1)));
            end
            7:
            begin
                put_byte(c, 1'b0);
                repeat (4) put_byte(8'h80, 1'b0);
                put_byte(8'h80 | 8'($urandom_range(0, 15)), 1'b0);
            end
            8:
            begin
                put_byte($urandom_range(0, 1) ? a : 8'($urandom_range(0, 255)), 1'b0);
                put_varint(32'd0, pad_width(), 1'b0);
            end
            9: put_add(len, pad_width(), 1'b0);
            10: put_add(len, pad_width(), 1'b0);
            11: put_copy(32'd1, g_prev_end, pad_width(), 1'b0);
            default:
            begin
                do
                    u = 8'($urandom_range(0, 255));
                while (u == a || u == c);
                put_byte(u, 1'b0);
                put_varint(len, pad_width(), 1'b0);
            end
        endcase
        repeat (4) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_idle();
        repeat (10) @(negedge clk);

        if (fault_count == 0 && expected_cmds.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/dpod_pkg.sv
rtl/dpod_stream_if.sv
rtl/dpod_step.sv
rtl/delta_patch_op_decoder.sv
tb/delta_patch_op_decoder_tb.sv
